// ===== hw/rtl/aabb_collision_resolver_macros.svh =====
// Assertion macros for the AABB collision resolver.
// Each macro expects signals named clock and reset in the scope of its use.
`ifndef AABB_COLLISION_RESOLVER_MACROS_SVH
`define AABB_COLLISION_RESOLVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AABB_ASSERT_IMPLY(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AABB_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== hw/rtl/aabb_pkg.sv =====
// Shared types and constants of the AABB collision resolver.
// Used by the channel interfaces and the top level; depends on nothing.
package aabb_pkg;

   // Configuration registers are all unsigned Q15.8, 23 bits wide.
   localparam int CFG_WIDTH       = 23;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int KIND_WIDTH      = 2;

   // Fraction bits of every coordinate and register value.
   localparam int FRAC_BITS       = 8;

   // Box width and height after reset: 16.0 in Q15.8.
   localparam logic [CFG_WIDTH-1:0] BOX_SIZE_RESET = CFG_WIDTH'(16 << FRAC_BITS);

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_BEGIN    = 2'd0,
      KIND_OBSTACLE = 2'd1,
      KIND_FINISH   = 2'd2,
      KIND_PLACE    = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MARGIN     = 2'd0,
      CSR_BOX_WIDTH  = 2'd1,
      CSR_BOX_HEIGHT = 2'd2
   } csr_index_type;

endpackage

// ===== hw/rtl/aabb_if.sv =====
// Valid/ready channel interfaces of the AABB collision resolver.
// Depends on aabb_pkg for the width of the item kind field.
interface aabb_req_if
   import aabb_pkg::*;
#(
   parameter int COORD_WIDTH = 24
);
   logic                          valid;
   logic                          ready;
   logic [KIND_WIDTH-1:0]         kind;
   logic signed [COORD_WIDTH-1:0] move_x;
   logic signed [COORD_WIDTH-1:0] move_y;
   logic signed [COORD_WIDTH-1:0] speed_x;
   logic signed [COORD_WIDTH-1:0] speed_y;
   logic signed [COORD_WIDTH-1:0] obstacle_left;
   logic signed [COORD_WIDTH-1:0] obstacle_right;
   logic signed [COORD_WIDTH-1:0] obstacle_top;
   logic signed [COORD_WIDTH-1:0] obstacle_bottom;

   modport source (
      output valid, kind, move_x, move_y, speed_x, speed_y,
             obstacle_left, obstacle_right, obstacle_top, obstacle_bottom,
      input  ready
   );
   modport sink (
      input  valid, kind, move_x, move_y, speed_x, speed_y,
             obstacle_left, obstacle_right, obstacle_top, obstacle_bottom,
      output ready
   );
endinterface

interface aabb_rsp_if #(
   parameter int COORD_WIDTH = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] final_x;
   logic signed [COORD_WIDTH-1:0] final_y;
   logic signed [COORD_WIDTH-1:0] final_speed_x;
   logic signed [COORD_WIDTH-1:0] final_speed_y;
   logic                          landed;

   modport source (
      output valid, final_x, final_y, final_speed_x, final_speed_y, landed,
      input  ready
   );
   modport sink (
      input  valid, final_x, final_y, final_speed_x, final_speed_y, landed,
      output ready
   );
endinterface

// ===== hw/rtl/aabb_collision_resolver.sv =====
// AABB collision resolver: input register, one pass of resolve logic, result register.
// Depends on aabb_pkg, the channel interfaces in aabb_if.sv and the assertion macros.
//
// Usage. Items arrive on req_chan (valid/ready). A begin item moves the box by an
// offset and latches its velocity, obstacle items each test one solid rectangle
// against the moved box and may snap the saved position against its edges,
// a finish item commits the saved position and returns one item on rsp_chan,
// and a place item sets the position absolutely. Only finish produces a result.
// The csr_ port writes margin, box width and box height; write them while idle.
// Throughput is one item per cycle while no finish item waits for a stalled result
// register: every item is resolved between the input register and the state and
// result registers, since each obstacle costs only a few adds and compares against
// the registered state. A finish item passes through the input register and then
// the result register before its result is valid.
// Reset clears the position, the saved position, the velocity and the landed
// flag to zero, sets the margin to zero and the box to 16.0 by 16.0.
// When the receiver stalls, the result waits in the result register. Items that
// produce no result keep flowing past it; a further finish item waits in the
// input register, and the input side is then held off until the result is taken.
module aabb_collision_resolver
   import aabb_pkg::*;
#(
   parameter int COORD_WIDTH = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   aabb_req_if.sink                   req_chan,
   aabb_rsp_if.source                 rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_wdata
);

`include "aabb_collision_resolver_macros.svh"

   localparam int W = COORD_WIDTH;
   // Internal width holds doubled coordinates plus doubled register values.
   localparam int EW = ((W > CFG_WIDTH) ? W : CFG_WIDTH) + 4;

   localparam logic signed [EW-1:0] COORD_MAX_E =
      signed'({{(EW-W+1){1'b0}}, {(W-1){1'b1}}});
   localparam logic signed [EW-1:0] COORD_MIN_E = -COORD_MAX_E - EW'(1);

   // Sign-extend a coordinate to the internal width.
   function automatic logic signed [EW-1:0] widen(input logic signed [W-1:0] v);
      return EW'(v);
   endfunction

   // Clamp an internal sum to the signed coordinate range.
   function automatic logic signed [W-1:0] clamp(input logic signed [EW-1:0] v);
      logic signed [W-1:0] r;
      if (v > COORD_MAX_E) begin
         r = W'(COORD_MAX_E);
      end else if (v < COORD_MIN_E) begin
         r = W'(COORD_MIN_E);
      end else begin
         r = W'(v);
      end
      return r;
   endfunction

   // Configuration registers.
   logic [CFG_WIDTH-1:0] margin_ff;
   logic [CFG_WIDTH-1:0] box_width_ff;
   logic [CFG_WIDTH-1:0] box_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff     <= '0;
         box_width_ff  <= BOX_SIZE_RESET;
         box_height_ff <= BOX_SIZE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MARGIN:     margin_ff     <= csr_wdata;
            CSR_BOX_WIDTH:  box_width_ff  <= csr_wdata;
            CSR_BOX_HEIGHT: box_height_ff <= csr_wdata;
            default: begin
               // Writes beyond the register list are dropped.
            end
         endcase
      end
   end

   // Input register. It is refilled whenever its item is resolved in the
   // same cycle, so back-to-back items pass at full rate.
   logic                in_valid_ff;
   kind_type            in_kind_ff;
   logic signed [W-1:0] in_move_x_ff, in_move_y_ff;
   logic signed [W-1:0] in_speed_x_ff, in_speed_y_ff;
   logic signed [W-1:0] in_left_ff, in_right_ff, in_top_ff, in_bottom_ff;

   logic advance;
   logic is_finish;

   // Result register.
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic signed [W-1:0] rsp_x_ff, rsp_y_ff, rsp_speed_x_ff, rsp_speed_y_ff;
   logic                rsp_landed_ff;

   // A finish item needs the result register free, or freed this cycle.
   assign is_finish = (in_kind_ff == KIND_FINISH);
   assign advance   = in_valid_ff && (!is_finish || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_kind_ff    <= kind_type'(req_chan.kind);
         in_move_x_ff  <= req_chan.move_x;
         in_move_y_ff  <= req_chan.move_y;
         in_speed_x_ff <= req_chan.speed_x;
         in_speed_y_ff <= req_chan.speed_y;
         in_left_ff    <= req_chan.obstacle_left;
         in_right_ff   <= req_chan.obstacle_right;
         in_top_ff     <= req_chan.obstacle_top;
         in_bottom_ff  <= req_chan.obstacle_bottom;
      end
   end

   // Motion state.
   logic signed [W-1:0] cur_x_ff, cur_y_ff, saved_x_ff, saved_y_ff;
   logic signed [W-1:0] vel_x_ff, vel_y_ff;
   logic                landed_ff;
   logic signed [W-1:0] cur_x_in, cur_y_in, saved_x_in, saved_y_in;
   logic signed [W-1:0] vel_x_in, vel_y_in;
   logic                landed_in;

   // Box edges at doubled scale, so half the width is never rounded.
   // y grows downward: the top of the box is the smaller y.
   logic signed [EW-1:0] w_e, h_e, m_e, hw_e;
   logic signed [EW-1:0] box_l2, box_r2, box_t2, box_b2;
   logic signed [EW-1:0] obs_l2, obs_r2, obs_t2, obs_b2;
   logic                 overlap, hit_bottom, hit_top, hit_right, hit_left;

   assign w_e  = signed'(EW'(box_width_ff));
   assign h_e  = signed'(EW'(box_height_ff));
   assign m_e  = signed'(EW'(margin_ff));
   assign hw_e = w_e >>> 1;

   assign box_l2 = (widen(cur_x_ff) <<< 1) - w_e;
   assign box_r2 = (widen(cur_x_ff) <<< 1) + w_e;
   assign box_t2 = (widen(cur_y_ff) <<< 1) - (h_e <<< 1);
   assign box_b2 = widen(cur_y_ff) <<< 1;

   assign obs_l2 = widen(in_left_ff) <<< 1;
   assign obs_r2 = widen(in_right_ff) <<< 1;
   assign obs_t2 = widen(in_top_ff) <<< 1;
   assign obs_b2 = widen(in_bottom_ff) <<< 1;

   // Strict overlap; the edges are not checked for order.
   assign overlap = (obs_l2 < box_r2) && (obs_r2 > box_l2)
                 && (obs_t2 < box_b2) && (obs_b2 > box_t2);

   // Side tests with the margin as tolerance.
   assign hit_bottom = (box_b2 - (m_e <<< 1)) < obs_t2;
   assign hit_top    = (box_t2 + (m_e <<< 1)) > obs_b2;
   assign hit_right  = (box_r2 - (m_e <<< 1)) < obs_l2;
   assign hit_left   = (box_l2 + (m_e <<< 1)) > obs_r2;

   always_comb begin
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      saved_x_in = saved_x_ff;
      saved_y_in = saved_y_ff;
      vel_x_in   = vel_x_ff;
      vel_y_in   = vel_y_ff;
      landed_in  = landed_ff;
      case (in_kind_ff)
         KIND_BEGIN: begin
            cur_x_in   = clamp(widen(cur_x_ff) + widen(in_move_x_ff));
            cur_y_in   = clamp(widen(cur_y_ff) + widen(in_move_y_ff));
            saved_x_in = cur_x_in;
            saved_y_in = cur_y_in;
            vel_x_in   = in_speed_x_ff;
            vel_y_in   = in_speed_y_ff;
            landed_in  = 1'b0;
         end
         KIND_OBSTACLE: begin
            if (overlap) begin
               // Falling onto the obstacle lands on its top; rising into it
               // puts the box just under its bottom.
               if (vel_y_ff > 0 && hit_bottom) begin
                  saved_y_in = in_top_ff;
                  vel_y_in   = '0;
                  landed_in  = 1'b1;
               end else if (vel_y_ff < 0 && hit_top) begin
                  saved_y_in = clamp(widen(in_bottom_ff) + h_e);
                  vel_y_in   = '0;
               end
               // Horizontal snap is independent of the vertical one.
               if (vel_x_ff > 0 && hit_right) begin
                  saved_x_in = clamp(widen(in_left_ff) - hw_e);
               end else if (vel_x_ff < 0 && hit_left) begin
                  saved_x_in = clamp(widen(in_right_ff) + hw_e);
               end
            end
         end
         KIND_FINISH: begin
            cur_x_in = saved_x_ff;
            cur_y_in = saved_y_ff;
         end
         KIND_PLACE: begin
            cur_x_in   = in_move_x_ff;
            cur_y_in   = in_move_y_ff;
            saved_x_in = in_move_x_ff;
            saved_y_in = in_move_y_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff   <= '0;
         cur_y_ff   <= '0;
         saved_x_ff <= '0;
         saved_y_ff <= '0;
         vel_x_ff   <= '0;
         vel_y_ff   <= '0;
         landed_ff  <= 1'b0;
      end else if (advance) begin
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         saved_x_ff <= saved_x_in;
         saved_y_ff <= saved_y_in;
         vel_x_ff   <= vel_x_in;
         vel_y_ff   <= vel_y_in;
         landed_ff  <= landed_in;
      end
   end

   // The result is taken from the state as it stands before the finish item.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (advance && is_finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_finish) begin
         rsp_x_ff       <= saved_x_ff;
         rsp_y_ff       <= saved_y_ff;
         rsp_speed_x_ff <= vel_x_ff;
         rsp_speed_y_ff <= vel_y_ff;
         rsp_landed_ff  <= landed_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.final_x       = rsp_x_ff;
   assign rsp_chan.final_y       = rsp_y_ff;
   assign rsp_chan.final_speed_x = rsp_speed_x_ff;
   assign rsp_chan.final_speed_y = rsp_speed_y_ff;
   assign rsp_chan.landed        = rsp_landed_ff;

   // A landing always stops the vertical motion until the next begin.
   `AABB_ASSERT_IMPLY(a_landed_stops_fall, landed_ff, vel_y_ff == '0, "landed with vertical speed")

   // Every resolved finish item leaves a result in the result register.
   `AABB_ASSERT_NEXT(a_finish_gives_result, advance && is_finish, rsp_valid_ff, "finish lost")

   // A landed result carries zero vertical speed.
   `AABB_ASSERT_IMPLY(a_result_landed_speed, rsp_valid_ff && rsp_landed_ff, rsp_speed_y_ff == '0, "landed result moving")

endmodule
